FILE: src/cdq_pkg.sv
package cdq_pkg;

	localparam int unsigned DepthDefault     = 16;
	localparam int unsigned DataWidthDefault = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_CONTAINS   = 3'd6,
		CMD_CLEAR      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_RESP
	} state_t;

	// Result flags handed from the sequencer to the output register.
	typedef struct packed {
		logic    hit;
		status_t status;
	} res_flags_t;

endpackage

FILE: src/circular_deque.sv
// Double-ended queue of DEPTH words held in a ring store.
// Commands enter on cmd/value under cmd_valid and cmd_ready; each command gives
// exactly one result word on data, hit, status, count, full_flag and
// empty_flag under res_valid and res_ready.
// The sequencer answers a push, a clear or any command that finds the deque
// empty directly; a pop or peek first passes a read state (the store has a
// registered read port), and contains passes a scan state, since the single
// read port and comparator walk the held entries from the front one a cycle.
// It then holds the result until the output register takes it. cmd_ready is
// low from the taking edge until the sequencer is idle again.
// A finished result waits in the output register, so the next command is
// taken while the receiver stalls; if the receiver holds off longer, the
// sequencer keeps its result and cmd_ready stays low until the word moves on.
// Reset empties the queue (both pointers and the count go to zero); the store
// itself is not cleared, as no entry is read before it has been written.
module circular_deque import cdq_pkg::*; #(
	parameter int unsigned DEPTH      = DepthDefault,
	parameter int unsigned DATA_WIDTH = DataWidthDefault,
	localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [2:0]                   cmd,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic signed [DATA_WIDTH-1:0] data,
	output logic                         hit,
	output logic [1:0]                   status,
	output logic [CW-1:0]                count,
	output logic                         full_flag,
	output logic                         empty_flag
);

	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	logic                  seq_valid, seq_ready;
	logic [DATA_WIDTH-1:0] seq_data;
	res_flags_t            seq_flags;
	logic [CW-1:0]         seq_count;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	res_flags_t            flags_q;
	logic [CW-1:0]         count_q;

	cdq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_valid),
		.in_ready  (cmd_ready),
		.in_cmd    (cmd_t'(cmd)),
		.in_value  (value),
		.res_valid (seq_valid),
		.res_ready (seq_ready),
		.res_data  (seq_data),
		.res_flags (seq_flags),
		.res_count (seq_count)
	);

	// The output register takes a new word when it is empty or being emptied.
	assign seq_ready = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_ready) begin
			out_valid_q <= seq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_valid && seq_ready) begin
			data_q  <= seq_data;
			flags_q <= seq_flags;
			count_q <= seq_count;
		end
	end

	assign res_valid  = out_valid_q;
	assign data       = data_q;
	assign hit        = flags_q.hit;
	assign status     = flags_q.status;
	assign count      = count_q;
	assign full_flag  = (count_q == FullCnt);
	assign empty_flag = (count_q == '0);

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_FULL |-> full_flag)
		else $error("dropped push reported while the deque was not full");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_EMPTY |-> empty_flag && !hit)
		else $error("empty status reported with entries held or a hit");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> count <= FullCnt)
		else $error("count beyond the capacity");

	a_busy_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command taken while one was in progress");

endmodule

FILE: src/cdq_ring.sv
module cdq_ring import cdq_pkg::*; #(
	parameter int unsigned DEPTH      = DepthDefault,
	parameter int unsigned DATA_WIDTH = DataWidthDefault,
	localparam int unsigned IW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [IW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/cdq_ctrl.sv
module cdq_ctrl import cdq_pkg::*; #(
	parameter int unsigned DEPTH      = DepthDefault,
	parameter int unsigned DATA_WIDTH = DataWidthDefault,
	localparam int unsigned IW        = $clog2(DEPTH),
	localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cmd_t                  in_cmd,
	input  logic [DATA_WIDTH-1:0] in_value,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [DATA_WIDTH-1:0] res_data,
	output res_flags_t            res_flags,
	output logic [CW-1:0]         res_count
);

	localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	state_t state_q, state_d;

	logic [IW-1:0]         head_q, tail_q, scan_ptr_q;
	logic [CW-1:0]         count_q, rem_q;
	logic [DATA_WIDTH-1:0] value_q, data_q;
	logic                  hit_q;
	status_t               status_q;

	logic                  mem_we, mem_re;
	logic [IW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_rdata;

	logic accept, no_entries, is_full, match, scan_last;
	logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec, scan_inc;

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
		return (i == LastIdx) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
		return (i == '0) ? LastIdx : i - 1'b1;
	endfunction

	cdq_ring #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (in_value),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign accept     = in_valid && in_ready;
	assign no_entries = (count_q == '0);
	assign is_full    = (count_q == FullCnt);
	assign head_inc   = idx_inc(head_q);
	assign head_dec   = idx_dec(head_q);
	assign tail_inc   = idx_inc(tail_q);
	assign tail_dec   = idx_dec(tail_q);
	assign scan_inc   = idx_inc(scan_ptr_q);
	// The shared comparator: one stored word against the target each cycle.
	assign match      = (mem_rdata == value_q);
	assign scan_last  = (rem_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_RESP;
					unique case (in_cmd) inside
						CMD_PUSH_FRONT: begin
							mem_we    = !is_full;
							mem_waddr = head_dec;
						end
						CMD_PUSH_BACK: begin
							mem_we    = !is_full;
							mem_waddr = tail_q;
						end
						CMD_POP_FRONT, CMD_PEEK_FRONT: begin
							mem_re    = !no_entries;
							mem_raddr = head_q;
							if (!no_entries) begin
								state_d = S_READ;
							end
						end
						CMD_POP_BACK, CMD_PEEK_BACK: begin
							mem_re    = !no_entries;
							mem_raddr = tail_dec;
							if (!no_entries) begin
								state_d = S_READ;
							end
						end
						CMD_CONTAINS: begin
							mem_re    = !no_entries;
							mem_raddr = head_q;
							if (!no_entries) begin
								state_d = S_SCAN;
							end
						end
						CMD_CLEAR: begin
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				state_d = S_RESP;
			end
			S_SCAN: begin
				mem_raddr = scan_ptr_q;
				if (scan_last) begin
					state_d = S_RESP;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Ring pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			case (in_cmd)
				CMD_PUSH_FRONT: begin
					if (!is_full) begin
						head_q  <= head_dec;
						count_q <= count_q + 1'b1;
					end
				end
				CMD_PUSH_BACK: begin
					if (!is_full) begin
						tail_q  <= tail_inc;
						count_q <= count_q + 1'b1;
					end
				end
				CMD_POP_FRONT: begin
					if (!no_entries) begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end
				end
				CMD_POP_BACK: begin
					if (!no_entries) begin
						tail_q  <= tail_dec;
						count_q <= count_q - 1'b1;
					end
				end
				CMD_CLEAR: begin
					head_q  <= '0;
					tail_q  <= '0;
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Result word and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q    <= in_value;
			data_q     <= '0;
			hit_q      <= 1'b0;
			status_q   <= ST_OK;
			scan_ptr_q <= head_inc;
			rem_q      <= count_q;
			case (in_cmd) inside
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (is_full) begin
						status_q <= ST_FULL;
					end
				end
				CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
					if (no_entries) begin
						data_q   <= '1;
						status_q <= ST_EMPTY;
					end
				end
				CMD_CONTAINS: begin
					if (no_entries) begin
						status_q <= ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == S_READ) begin
			data_q <= mem_rdata;
		end else if (state_q == S_SCAN) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			scan_ptr_q <= scan_inc;
			rem_q      <= rem_q - 1'b1;
		end
	end

	assign res_data         = data_q;
	assign res_flags.hit    = hit_q;
	assign res_flags.status = status_q;
	assign res_count        = count_q;

endmodule

FILE: tb/circular_deque_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deque, keeps its own copy of the ring and
// checks every result word against the oldest prediction.
module circular_deque_checker import cdq_pkg::*; #(
	parameter int unsigned DEPTH      = DepthDefault,
	parameter int unsigned DATA_WIDTH = DataWidthDefault,
	localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  logic [2:0]                   cmd,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  logic signed [DATA_WIDTH-1:0] data,
	input  logic                         hit,
	input  logic [1:0]                   status,
	input  logic [CW-1:0]                count,
	input  logic                         full_flag,
	input  logic                         empty_flag,
	output int                           mismatches,
	output int                           outstanding
);

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		logic                  hit;
		logic [1:0]            status;
		logic [CW-1:0]         count;
		logic                  full;
		logic                  empty;
	} deque_reply_t;

	logic [DATA_WIDTH-1:0] ring [DEPTH];
	int unsigned           front_pos;
	int unsigned           back_pos;
	int unsigned           held;
	deque_reply_t          replies_due [$];
	deque_reply_t          want;

	function automatic int unsigned step_fwd(int unsigned p);
		return (p + 1) % DEPTH;
	endfunction

	function automatic int unsigned step_back(int unsigned p);
		return (p + DEPTH - 1) % DEPTH;
	endfunction

	// Applies one command to the shadow deque and returns the word it should give.
	function automatic deque_reply_t run_command(cmd_t op, logic [DATA_WIDTH-1:0] v);
		deque_reply_t r;
		int unsigned  p;
		int unsigned  i;
		r = '0;
		case (op)
		CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
			if (held == DEPTH) begin
				r.status = ST_FULL;
			end else if (op == CMD_PUSH_FRONT) begin
				front_pos = step_back(front_pos);
				ring[front_pos] = v;
				held++;
			end else begin
				ring[back_pos] = v;
				back_pos = step_fwd(back_pos);
				held++;
			end
		end
		CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
			if (held == 0) begin
				r.data   = '1;
				r.status = ST_EMPTY;
			end else if (op == CMD_POP_FRONT) begin
				r.data = ring[front_pos];
				front_pos = step_fwd(front_pos);
				held--;
			end else if (op == CMD_POP_BACK) begin
				back_pos = step_back(back_pos);
				r.data = ring[back_pos];
				held--;
			end else if (op == CMD_PEEK_FRONT) begin
				r.data = ring[front_pos];
			end else begin
				r.data = ring[step_back(back_pos)];
			end
		end
		CMD_CONTAINS: begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				p = front_pos;
				for (i = 0; i < held; i++) begin
					if (ring[p] == v)
						r.hit = 1'b1;
					p = step_fwd(p);
				end
			end
		end
		default: begin
			// Clear drops the pointers but leaves the store contents alone.
			front_pos = 0;
			back_pos  = 0;
			held      = 0;
		end
		endcase
		r.count = CW'(held);
		r.full  = (held == DEPTH);
		r.empty = (held == 0);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_pos  = 0;
			back_pos   = 0;
			held       = 0;
			mismatches = 0;
			replies_due.delete();
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("result word with no command waiting for it");
				end else begin
					want = replies_due.pop_front();
					if (data !== want.data)
						report_mismatch($sformatf("data: got %h, expected %h", data, want.data));
					if (hit !== want.hit)
						report_mismatch($sformatf("hit: got %b, expected %b", hit, want.hit));
					if (status !== want.status)
						report_mismatch($sformatf("status: got %0d, expected %0d",
							status, want.status));
					if (count !== want.count)
						report_mismatch($sformatf("count: got %0d, expected %0d",
							count, want.count));
					if (full_flag !== want.full)
						report_mismatch($sformatf("full_flag: got %b, expected %b",
							full_flag, want.full));
					if (empty_flag !== want.empty)
						report_mismatch($sformatf("empty_flag: got %b, expected %b",
							empty_flag, want.empty));
				end
			end
			if (cmd_valid && cmd_ready)
				replies_due.push_back(run_command(cmd_t'(cmd), value));
			outstanding <= replies_due.size();
		end
	end

endmodule

FILE: tb/circular_deque_tb.sv
`timescale 1ns / 1ps

module circular_deque_tb;
	import cdq_pkg::*;

	localparam int unsigned Depth      = DepthDefault;
	localparam int unsigned DataWidth  = DataWidthDefault;
	localparam int unsigned CountWidth = $clog2(Depth + 1);
	localparam int          NumWords   = 1225;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cmd_valid = 1'b0;
	logic                        cmd_ready;
	cmd_t                        cmd       = CMD_PUSH_FRONT;
	logic signed [DataWidth-1:0] value     = '0;
	logic                        res_valid;
	logic                        res_ready = 1'b0;
	logic signed [DataWidth-1:0] data;
	logic                        hit;
	logic [1:0]                  status;
	logic [CountWidth-1:0]       count;
	logic                        full_flag;
	logic                        empty_flag;
	int                          mismatches;
	int                          outstanding;

	bit                          tx_calm = 1'b0;
	bit                          rx_calm = 1'b0;
	int                          sent    = 0;
	logic [DataWidth-1:0]        pushed_vals [$];

	always #4 clk = ~clk;

	circular_deque #(
		.DEPTH      (Depth),
		.DATA_WIDTH (DataWidth)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.value      (value),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.data       (data),
		.hit        (hit),
		.status     (status),
		.count      (count),
		.full_flag  (full_flag),
		.empty_flag (empty_flag)
	);

	circular_deque_checker #(
		.DEPTH      (Depth),
		.DATA_WIDTH (DataWidth)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.value       (value),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.data        (data),
		.hit         (hit),
		.status      (status),
		.count       (count),
		.full_flag   (full_flag),
		.empty_flag  (empty_flag),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic int draw_gap(bit calm);
		return calm ? 0 : int'($urandom_range(0, 13));
	endfunction

	function automatic logic [DataWidth-1:0] draw_value();
		logic [DataWidth-1:0] v;
		case ($urandom_range(0, 9))
		0:       v = {1'b1, {(DataWidth - 1){1'b0}}};
		1:       v = {1'b0, {(DataWidth - 1){1'b1}}};
		2:       v = '0;
		3:       v = '1;
		4, 5:    v = DataWidth'($urandom_range(0, 7));
		default: v = DataWidth'($urandom);
		endcase
		return v;
	endfunction

	// Mostly a value still likely to be held, so that searches hit as well as miss.
	function automatic logic [DataWidth-1:0] draw_target();
		if (pushed_vals.size() > 0 && $urandom_range(0, 4) != 0)
			return pushed_vals[$urandom_range(0, pushed_vals.size() - 1)];
		return draw_value();
	endfunction

	task automatic send_word(cmd_t op, logic [DataWidth-1:0] v);
		int gap;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= op;
		value     <= v;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sent++;
		if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
			pushed_vals.push_back(v);
			if (pushed_vals.size() > 12)
				void'(pushed_vals.pop_front());
		end
		if ($urandom_range(0, 59) == 0)
			tx_calm = !tx_calm;
	endtask

	task automatic send_fill();
		repeat (Depth + $urandom_range(0, 3))
			send_word($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, draw_value());
		send_word(CMD_CONTAINS, draw_target());
	endtask

	task automatic send_drain();
		cmd_t op;
		repeat (Depth + $urandom_range(0, 3)) begin
			if ($urandom_range(0, 3) == 0)
				op = $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
			else
				op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
			send_word(op, DataWidth'($urandom));
		end
	endtask

	task automatic send_mixed();
		cmd_t op;
		repeat ($urandom_range(4, 20)) begin
			op = cmd_t'(3'($urandom_range(0, 6)));
			if (op == CMD_CONTAINS)
				send_word(op, draw_target());
			else if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK)
				send_word(op, draw_value());
			else
				send_word(op, DataWidth'($urandom));
		end
	endtask

	// The receiver draws a stall before taking each result word.
	initial begin : result_sink
		int gap;
		forever begin
			gap = draw_gap(rx_calm);
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			if ($urandom_range(0, 59) == 0)
				rx_calm = !rx_calm;
		end
	end

	initial begin : stimulus
		logic [DataWidth-1:0] v;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pops, peeks and a search on an empty deque first.
		send_word(CMD_POP_FRONT, '1);
		send_word(CMD_POP_BACK, '0);
		send_word(CMD_PEEK_FRONT, '1);
		send_word(CMD_PEEK_BACK, '0);
		send_word(CMD_CONTAINS, '0);
		// Fill to capacity from both ends, extreme values first.
		for (int i = 0; i < Depth; i++) begin
			case (i)
			0:       v = {1'b0, {(DataWidth - 1){1'b1}}};
			1:       v = {1'b1, {(DataWidth - 1){1'b0}}};
			2:       v = '0;
			3:       v = '1;
			default: v = DataWidth'($urandom);
			endcase
			send_word(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, v);
		end
		// Both pushes to a full deque must be dropped.
		send_word(CMD_PUSH_FRONT, DataWidth'(32'h1234_5678));
		send_word(CMD_PUSH_BACK, DataWidth'(32'h8765_4321));
		send_word(CMD_CONTAINS, {1'b1, {(DataWidth - 1){1'b0}}});
		send_word(CMD_CLEAR, '1);
		send_word(CMD_PEEK_FRONT, '0);

		while (sent < NumWords) begin
			case ($urandom_range(0, 9))
			0, 1:    send_fill();
			2, 3:    send_drain();
			4:       send_word(CMD_CLEAR, DataWidth'($urandom));
			default: send_mixed();
			endcase
		end
		cmd_valid <= 1'b0;

		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("circular_deque_tb passed");
		else
			$display("circular_deque_tb failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("circular_deque_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/cdq_pkg.sv
src/cdq_ring.sv
src/cdq_ctrl.sv
src/circular_deque.sv
tb/circular_deque_checker.sv
tb/circular_deque_tb.sv
